// File: sv/shape_pair_overlap_test_assert.svh
// Assertion macros used by the shape pair overlap test top level
`ifndef SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset
`define SPOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset
`define SPOT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/spot_pkg.sv
// Types and constants of the shape pair overlap test pipeline
package spot_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned KindW  = 2;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SumW   = SizeW + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned RadSqW = 2 * SumW;

  localparam logic [KindW-1:0] KIND_NONE   = 2'd0;
  localparam logic [KindW-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KindW-1:0] KIND_BOX    = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CC   = 2'd1,
    MODE_BB   = 2'd2,
    MODE_CB   = 2'd3
  } spot_mode_e;

  // After the difference stage
  typedef struct packed {
    logic             valid;
    spot_mode_e       mode;
    logic [DiffW-1:0] adx;
    logic [DiffW-1:0] ady;
    logic [SumW-1:0]  lim_x;
    logic [SumW-1:0]  lim_y;
    logic [SumW-1:0]  rad;
  } spot_s1_t;

  // After the excess stage
  typedef struct packed {
    logic             valid;
    spot_mode_e       mode;
    logic             box_ok;
    logic [DiffW-1:0] ex_x;
    logic [DiffW-1:0] ex_y;
    logic [SumW-1:0]  rad;
  } spot_s2_t;

  // After the square stage
  typedef struct packed {
    logic              valid;
    spot_mode_e        mode;
    logic              box_ok;
    logic [SqW-1:0]    sq_x;
    logic [SqW-1:0]    sq_y;
    logic [RadSqW-1:0] rad_sq;
  } spot_s3_t;

endpackage

// File: sv/shape_pair_overlap_test.sv
// Top level of the shape pair overlap test: pipeline and final compare
//
// One shape pair is taken on every cycle that start_i is high; busy_o stays
// low, since nothing in the pipeline waits. The answer comes out as hit_o
// with done_o high for one cycle; the receiver cannot hold it off. The
// four register stages are: centre differences, excess beyond the box or
// limit, squares (two 17x17 multipliers and one 16x16), and the final sum
// and compare. Pairs flow in order with no gaps added, so sustained
// throughput is one pair per clock.
module shape_pair_overlap_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [spot_pkg::KindW-1:0]         a_shape_i,
  input  logic signed [spot_pkg::CoordW-1:0] a_x_i,
  input  logic signed [spot_pkg::CoordW-1:0] a_y_i,
  input  logic [spot_pkg::SizeW-1:0]         a_size_x_i,
  input  logic [spot_pkg::SizeW-1:0]         a_size_y_i,
  input  logic [spot_pkg::KindW-1:0]         b_shape_i,
  input  logic signed [spot_pkg::CoordW-1:0] b_x_i,
  input  logic signed [spot_pkg::CoordW-1:0] b_y_i,
  input  logic [spot_pkg::SizeW-1:0]         b_size_x_i,
  input  logic [spot_pkg::SizeW-1:0]         b_size_y_i,
  output logic                               done_o,
  output logic                               hit_o
);
  import spot_pkg::*;

  `include "shape_pair_overlap_test_assert.svh"

  spot_s1_t        s1;
  spot_s2_t        s2;
  spot_s3_t        s3;
  logic [SqW:0]    dist_sq;
  logic            hit_d, hit_q;
  logic            done_q;

  assign busy_o = 1'b0;

  spot_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .a_shape_i  (a_shape_i),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .a_size_x_i (a_size_x_i),
    .a_size_y_i (a_size_y_i),
    .b_shape_i  (b_shape_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .b_size_x_i (b_size_x_i),
    .b_size_y_i (b_size_y_i),
    .s1_o       (s1)
  );

  spot_excess u_excess (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  spot_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s2_i   (s2),
    .s3_o   (s3)
  );

  // Sum the squared distances and compare against the squared radius
  assign dist_sq = (SqW + 1)'(s3.sq_x) + (SqW + 1)'(s3.sq_y);

  always_comb begin
    unique case (s3.mode)
      MODE_CC, MODE_CB: hit_d = dist_sq <= (SqW + 1)'(s3.rad_sq);
      MODE_BB:          hit_d = s3.box_ok;
      MODE_NONE:        hit_d = 1'b0;
      default:          hit_d = 1'b0;
    endcase
  end

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign done_o = done_q;
  assign hit_o  = hit_q & done_q;

  `SPOT_ASSERT_IMP(a_latency, start_i && !busy_o, ##4 done_o, "accepted pair gave no result")
  `SPOT_ASSERT_IMP(a_no_ghost, done_o, $past(start_i, 4), "result without an accepted pair")
  `SPOT_ASSERT_NXT(a_none_miss, s3.valid && s3.mode == MODE_NONE, !hit_o,
                   "pair with no shape reported a hit")

endmodule

// File: sv/spot_prep.sv
// Stage 1: classify the pair, take centre distances and pick size limits
module spot_prep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [spot_pkg::KindW-1:0]     a_shape_i,
  input  logic signed [spot_pkg::CoordW-1:0] a_x_i,
  input  logic signed [spot_pkg::CoordW-1:0] a_y_i,
  input  logic [spot_pkg::SizeW-1:0]     a_size_x_i,
  input  logic [spot_pkg::SizeW-1:0]     a_size_y_i,
  input  logic [spot_pkg::KindW-1:0]     b_shape_i,
  input  logic signed [spot_pkg::CoordW-1:0] b_x_i,
  input  logic signed [spot_pkg::CoordW-1:0] b_y_i,
  input  logic [spot_pkg::SizeW-1:0]     b_size_x_i,
  input  logic [spot_pkg::SizeW-1:0]     b_size_y_i,
  output spot_pkg::spot_s1_t             s1_o
);
  import spot_pkg::*;

  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0]        adx, ady;
  spot_mode_e              mode;
  logic [SumW-1:0]         lim_x, lim_y, rad;
  logic                    valid_q;
  spot_s1_t                s1_d, s1_q;

  // Take signed centre differences and their magnitudes
  assign dx  = DiffW'(a_x_i) - DiffW'(b_x_i);
  assign dy  = DiffW'(a_y_i) - DiffW'(b_y_i);
  assign adx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign ady = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

  // Pick the pair mode, the per-axis limits and the radius to test against
  always_comb begin
    mode  = MODE_NONE;
    lim_x = '0;
    lim_y = '0;
    rad   = '0;
    priority if (a_shape_i == KIND_CIRCLE && b_shape_i == KIND_CIRCLE) begin
      mode = MODE_CC;
      rad  = SumW'(a_size_x_i) + SumW'(b_size_x_i);
    end else if (a_shape_i == KIND_BOX && b_shape_i == KIND_BOX) begin
      mode  = MODE_BB;
      lim_x = SumW'(a_size_x_i) + SumW'(b_size_x_i);
      lim_y = SumW'(a_size_y_i) + SumW'(b_size_y_i);
    end else if (a_shape_i == KIND_CIRCLE && b_shape_i == KIND_BOX) begin
      mode  = MODE_CB;
      lim_x = SumW'(b_size_x_i);
      lim_y = SumW'(b_size_y_i);
      rad   = SumW'(a_size_x_i);
    end else if (a_shape_i == KIND_BOX && b_shape_i == KIND_CIRCLE) begin
      mode  = MODE_CB;
      lim_x = SumW'(a_size_x_i);
      lim_y = SumW'(a_size_y_i);
      rad   = SumW'(b_size_x_i);
    end else begin
      mode = MODE_NONE;
    end
  end

  always_comb begin
    s1_d       = '0;
    s1_d.valid = start_i;
    s1_d.mode  = mode;
    s1_d.adx   = adx;
    s1_d.ady   = ady;
    s1_d.lim_x = lim_x;
    s1_d.lim_y = lim_y;
    s1_d.rad   = rad;
  end

  // Track the beat valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  // Load the payload every cycle
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  always_comb begin
    s1_o       = s1_q;
    s1_o.valid = valid_q;
  end

endmodule

// File: sv/spot_excess.sv
// Stage 2: distance beyond the limit per axis, and the box overlap check
module spot_excess (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spot_pkg::spot_s1_t s1_i,
  output spot_pkg::spot_s2_t s2_o
);
  import spot_pkg::*;

  logic [DiffW-1:0] lim_xw, lim_yw;
  logic             over_x, over_y;
  logic             valid_q;
  spot_s2_t         s2_d, s2_q;

  assign lim_xw = DiffW'(s1_i.lim_x);
  assign lim_yw = DiffW'(s1_i.lim_y);
  assign over_x = s1_i.adx > lim_xw;
  assign over_y = s1_i.ady > lim_yw;

  // Clamp to the box edge: keep only the part beyond the limit
  always_comb begin
    s2_d        = '0;
    s2_d.valid  = s1_i.valid;
    s2_d.mode   = s1_i.mode;
    s2_d.box_ok = !over_x && !over_y;
    s2_d.ex_x   = over_x ? s1_i.adx - lim_xw : '0;
    s2_d.ex_y   = over_y ? s1_i.ady - lim_yw : '0;
    s2_d.rad    = s1_i.rad;
  end

  // Track the beat valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  always_comb begin
    s2_o       = s2_q;
    s2_o.valid = valid_q;
  end

endmodule

// File: sv/spot_square.sv
// Stage 3: square the per-axis distances and the radius
module spot_square (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spot_pkg::spot_s2_t s2_i,
  output spot_pkg::spot_s3_t s3_o
);
  import spot_pkg::*;

  logic     valid_q;
  spot_s3_t s3_d, s3_q;

  // Three independent multipliers, registered right after
  always_comb begin
    s3_d        = '0;
    s3_d.valid  = s2_i.valid;
    s3_d.mode   = s2_i.mode;
    s3_d.box_ok = s2_i.box_ok;
    s3_d.sq_x   = SqW'(s2_i.ex_x) * SqW'(s2_i.ex_x);
    s3_d.sq_y   = SqW'(s2_i.ex_y) * SqW'(s2_i.ex_y);
    s3_d.rad_sq = RadSqW'(s2_i.rad) * RadSqW'(s2_i.rad);
  end

  // Track the beat valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s2_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  always_comb begin
    s3_o       = s3_q;
    s3_o.valid = valid_q;
  end

endmodule

// File: tb/sv/tb_shape_pair_overlap_test.sv
// Self-checking testbench for the shape pair overlap test pipeline
`timescale 1ns / 1ps

module tb_shape_pair_overlap_test;
  import spot_pkg::*;

  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned PHASE_PAIRS  = 210;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         size_x;
    logic [SizeW-1:0]         size_y;
  } shape_t;

  // Predicts the hit of each accepted pair and matches the strobed answers in order
  class overlap_scoreboard;
    bit          expected_hits[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    static function longint clamp_to(longint v, longint lo, longint hi);
      longint t;
      t = (v < hi) ? v : hi;
      return (t > lo) ? t : lo;
    endfunction

    // Exact overlap decision, all terms at full width
    static function bit overlap_of(shape_t p, shape_t q);
      shape_t ring, bx;
      longint dx, dy, rsum, nx, ny;
      bit     hit;
      hit = 1'b0;
      if (p.kind == KIND_CIRCLE && q.kind == KIND_CIRCLE) begin
        dx   = longint'(p.x) - longint'(q.x);
        dy   = longint'(p.y) - longint'(q.y);
        rsum = longint'(p.size_x) + longint'(q.size_x);
        hit  = (dx * dx + dy * dy <= rsum * rsum);
      end else if (p.kind == KIND_BOX && q.kind == KIND_BOX) begin
        dx  = longint'(p.x) - longint'(q.x);
        dy  = longint'(p.y) - longint'(q.y);
        dx  = (dx < 0) ? -dx : dx;
        dy  = (dy < 0) ? -dy : dy;
        hit = (dx <= longint'(p.size_x) + longint'(q.size_x)) &&
              (dy <= longint'(p.size_y) + longint'(q.size_y));
      end else if ((p.kind == KIND_CIRCLE && q.kind == KIND_BOX) ||
                   (p.kind == KIND_BOX && q.kind == KIND_CIRCLE)) begin
        ring = (p.kind == KIND_CIRCLE) ? p : q;
        bx   = (p.kind == KIND_CIRCLE) ? q : p;
        // Clamp the circle centre onto the box, then measure to that point
        nx  = clamp_to(longint'(ring.x), longint'(bx.x) - longint'(bx.size_x),
                       longint'(bx.x) + longint'(bx.size_x));
        ny  = clamp_to(longint'(ring.y), longint'(bx.y) - longint'(bx.size_y),
                       longint'(bx.y) + longint'(bx.size_y));
        dx  = longint'(ring.x) - nx;
        dy  = longint'(ring.y) - ny;
        hit = (dx * dx + dy * dy <= longint'(ring.size_x) * longint'(ring.size_x));
      end
      return hit;
    endfunction

    function void note_pair(shape_t a, shape_t b);
      expected_hits.push_back(overlap_of(a, b));
    endfunction

    function void check_hit(logic actual);
      bit want;
      if (expected_hits.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("hit strobe with no pair pending: got %b at %0t", actual, $realtime);
      end else begin
        want = expected_hits.pop_front();
        if (actual !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("hit differs: expected %0d got %b at %0t", want, actual, $realtime);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [KindW-1:0]         a_shape_i = '0;
  logic signed [CoordW-1:0] a_x_i = '0;
  logic signed [CoordW-1:0] a_y_i = '0;
  logic [SizeW-1:0]         a_size_x_i = '0;
  logic [SizeW-1:0]         a_size_y_i = '0;
  logic [KindW-1:0]         b_shape_i = '0;
  logic signed [CoordW-1:0] b_x_i = '0;
  logic signed [CoordW-1:0] b_y_i = '0;
  logic [SizeW-1:0]         b_size_x_i = '0;
  logic [SizeW-1:0]         b_size_y_i = '0;
  logic                     done_o;
  logic                     hit_o;

  overlap_scoreboard sb;
  int unsigned       idle_pct = 29;
  int unsigned       cycle_count = 0;

  shape_pair_overlap_test DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .a_shape_i  (a_shape_i),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .a_size_x_i (a_size_x_i),
    .a_size_y_i (a_size_y_i),
    .b_shape_i  (b_shape_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .b_size_x_i (b_size_x_i),
    .b_size_y_i (b_size_y_i),
    .done_o     (done_o),
    .hit_o      (hit_o)
  );

  // Toggle the clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shape_pair_overlap_test: mismatch");
      $finish;
    end
  end

  // Check every strobed answer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0)
      sb.check_hit(hit_o);
  end

  function automatic shape_t mk(logic [KindW-1:0] k, int x, int y, int sx, int sy);
    shape_t s;
    s.kind   = k;
    s.x      = CoordW'(x);
    s.y      = CoordW'(y);
    s.size_x = SizeW'(sx);
    s.size_y = SizeW'(sy);
    return s;
  endfunction

  function automatic logic [KindW-1:0] random_kind();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? KIND_NONE : KIND_SPARE;
    return $urandom_range(0, 1) ? KIND_CIRCLE : KIND_BOX;
  endfunction

  // Build a random pair: some fully random, most placed near each other or on the edge
  function automatic void random_pair(output shape_t a, output shape_t b);
    int flavor, size_max, span, dx, dy, tmp;
    a.kind = random_kind();
    b.kind = random_kind();
    a.x = CoordW'($urandom);
    a.y = CoordW'($urandom);
    flavor = $urandom_range(0, 3);
    if (flavor == 0) begin
      b.x = CoordW'($urandom);
      b.y = CoordW'($urandom);
      a.size_x = SizeW'($urandom);
      a.size_y = SizeW'($urandom);
      b.size_x = SizeW'($urandom);
      b.size_y = SizeW'($urandom);
    end else begin
      size_max = ($urandom_range(0, 7) == 0) ? 32767 : 2047;
      a.size_x = SizeW'($urandom_range(0, size_max));
      a.size_y = SizeW'($urandom_range(0, size_max));
      b.size_x = SizeW'($urandom_range(0, size_max));
      b.size_y = SizeW'($urandom_range(0, size_max));
      span = int'(a.size_x) + int'(b.size_x);
      if (flavor == 3) begin
        // Sit right on the contact distance, off by at most one step
        dx = ($urandom_range(0, 1) ? span : -span) + int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
        if ($urandom_range(0, 1)) begin
          tmp = dx;
          dx  = dy;
          dy  = tmp;
        end
      end else begin
        span = span + 64;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
      end
      b.x = a.x + CoordW'(dx);
      b.y = a.y + CoordW'(dy);
    end
  endfunction

  // Present one pair, idling first at the current rate, and hold it until taken
  task automatic send_pair(shape_t a, shape_t b);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    while (!taken) begin
      @(negedge clk_i);
      start_i    = 1'b1;
      a_shape_i  = a.kind;
      a_x_i      = a.x;
      a_y_i      = a.y;
      a_size_x_i = a.size_x;
      a_size_y_i = a.size_y;
      b_shape_i  = b.kind;
      b_x_i      = b.x;
      b_y_i      = b.y;
      b_size_x_i = b.size_x;
      b_size_y_i = b.size_y;
      @(posedge clk_i);
      if (busy_o === 1'b0) begin
        taken = 1'b1;
        sb.note_pair(a, b);
      end
    end
  endtask

  // Drop start and hold off until every pending answer has come back
  task automatic drain_answers();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    shape_t      a, b;
    int unsigned phase_pct[3];
    phase_pct = '{29, 87, 0};
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs: empty and spare kinds, contact edges, extremes
    send_pair(mk(KIND_NONE, 0, 0, 0, 0), mk(KIND_NONE, 0, 0, 0, 0));
    send_pair(mk(KIND_NONE, 5, 5, 100, 100), mk(KIND_CIRCLE, 5, 5, 100, 0));
    send_pair(mk(KIND_BOX, 0, 0, 50, 50), mk(KIND_NONE, 0, 0, 50, 50));
    send_pair(mk(KIND_SPARE, 0, 0, 80, 80), mk(KIND_CIRCLE, 0, 0, 80, 0));
    send_pair(mk(KIND_BOX, 0, 0, 80, 80), mk(KIND_SPARE, 0, 0, 80, 80));
    send_pair(mk(KIND_CIRCLE, 0, 0, 16, 0), mk(KIND_CIRCLE, 48, 0, 32, 0));
    send_pair(mk(KIND_CIRCLE, 0, 0, 16, 0), mk(KIND_CIRCLE, 49, 0, 32, 0));
    send_pair(mk(KIND_CIRCLE, 0, 0, 20, 0), mk(KIND_CIRCLE, 30, 40, 30, 0));
    send_pair(mk(KIND_CIRCLE, 0, 0, 20, 0), mk(KIND_CIRCLE, 30, 41, 30, 0));
    send_pair(mk(KIND_CIRCLE, -32768, -32768, 32767, 32767),
              mk(KIND_CIRCLE, 32767, 32767, 32767, 32767));
    send_pair(mk(KIND_CIRCLE, -32768, 0, 32767, 0), mk(KIND_CIRCLE, 32766, 0, 32767, 0));
    send_pair(mk(KIND_CIRCLE, 7, 7, 0, 0), mk(KIND_CIRCLE, 7, 7, 0, 0));
    send_pair(mk(KIND_CIRCLE, 7, 7, 0, 0), mk(KIND_CIRCLE, 8, 7, 0, 0));
    // Circle height must play no part
    send_pair(mk(KIND_CIRCLE, 0, 0, 10, 32767), mk(KIND_CIRCLE, 0, 100, 10, 32767));
    send_pair(mk(KIND_BOX, 0, 0, 10, 10), mk(KIND_BOX, 20, 5, 10, 10));
    send_pair(mk(KIND_BOX, 0, 0, 10, 10), mk(KIND_BOX, 0, 21, 10, 10));
    send_pair(mk(KIND_BOX, -32768, -32768, 32767, 32767),
              mk(KIND_BOX, 32767, 32767, 32767, 32767));
    send_pair(mk(KIND_BOX, -32768, -32768, 32767, 32767),
              mk(KIND_BOX, 32766, 32766, 32767, 32767));
    send_pair(mk(KIND_BOX, 3, 3, 0, 0), mk(KIND_BOX, 3, 3, 0, 0));
    send_pair(mk(KIND_CIRCLE, 13, 14, 5, 0), mk(KIND_BOX, 0, 0, 10, 10));
    send_pair(mk(KIND_BOX, 0, 0, 10, 10), mk(KIND_CIRCLE, 13, 14, 4, 32767));
    send_pair(mk(KIND_CIRCLE, 2, -3, 1, 0), mk(KIND_BOX, 0, 0, 100, 100));
    send_pair(mk(KIND_CIRCLE, -32768, -32768, 32767, 0),
              mk(KIND_BOX, 32767, 32767, 32767, 32767));
    send_pair(mk(KIND_BOX, 32767, -32768, 32767, 0), mk(KIND_CIRCLE, 0, 32767, 32767, 0));
    send_pair(mk(KIND_BOX, 0, 0, 40, 0), mk(KIND_CIRCLE, 20, 9, 9, 0));

    // Random phases: sender idles rarely, then often, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        random_pair(a, b);
        send_pair(a, b);
      end
      drain_answers();
    end

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("shape_pair_overlap_test: match");
    end else begin
      $display("shape_pair_overlap_test: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/spot_pkg.sv
sv/spot_prep.sv
sv/spot_excess.sv
sv/spot_square.sv
sv/shape_pair_overlap_test.sv
tb/sv/tb_shape_pair_overlap_test.sv
